// ===== rtl/utf16_to_utf8_transcoder_assert.svh =====
// Assertion macros for the UTF-16 to UTF-8 transcoder.
// Expects clk_i and rst_ni in the scope of use.
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// same-cycle implication
`define U16U8_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U16U8_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u16u8_pkg.sv =====
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// No dependencies.
`timescale 1ns / 1ps

package u16u8_pkg;

  localparam logic [15:0] LEAD_MIN   = 16'hD800;
  localparam logic [15:0] LEAD_MAX   = 16'hDBFF;
  localparam logic [15:0] TRAIL_MIN  = 16'hDC00;
  localparam logic [15:0] TRAIL_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [7:0]  SUBST_CHAR = 8'h3F;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_unit;
    logic        end_of_string;
    logic [15:0] bytes_so_far;
  } byte_t;

  typedef struct packed {
    logic            hold;
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
  } enc_t;

endpackage

// ===== rtl/u16u8_intf.sv =====
// Valid/ready channel interfaces of the transcoder.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

interface u16u8_unit_if import u16u8_pkg::*; ();
  logic  valid;
  logic  ready;
  unit_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface u16u8_byte_if import u16u8_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/u16u8_encoder.sv =====
// Surrogate resolution and UTF-8 byte encoding of one code unit.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_encoder import u16u8_pkg::*; (
  input  logic [15:0] unit_i,
  input  logic        last_i,
  input  logic        pend_valid_i,
  input  logic [9:0]  pend_bits_i,
  output enc_t        enc_o
);

  logic        is_lead;
  logic        is_trail;
  logic [20:0] cp;

  assign is_lead  = (unit_i >= LEAD_MIN) && (unit_i <= LEAD_MAX);
  assign is_trail = (unit_i >= TRAIL_MIN) && (unit_i <= TRAIL_MAX);

  always_comb begin
    enc_o = '0;
    cp    = {5'd0, unit_i};
    if (is_lead) begin
      cp         = {13'd0, SUBST_CHAR};
      enc_o.hold = !last_i;
    end else if (is_trail) begin
      cp = pend_valid_i ? (SUPP_BASE + {1'b0, pend_bits_i, unit_i[9:0]})
                        : {13'd0, SUBST_CHAR};
    end

    priority if (cp < 21'h80) begin
      enc_o.nbytes   = 3'd1;
      enc_o.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      enc_o.nbytes   = 3'd2;
      enc_o.bytes[0] = {3'b110, cp[10:6]};
      enc_o.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      enc_o.nbytes   = 3'd3;
      enc_o.bytes[0] = {4'b1110, cp[15:12]};
      enc_o.bytes[1] = {2'b10, cp[11:6]};
      enc_o.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      enc_o.nbytes   = 3'd4;
      enc_o.bytes[0] = {5'b11110, cp[20:18]};
      enc_o.bytes[1] = {2'b10, cp[17:12]};
      enc_o.bytes[2] = {2'b10, cp[11:6]};
      enc_o.bytes[3] = {2'b10, cp[5:0]};
    end

    if (enc_o.hold) begin
      enc_o.nbytes = 3'd0;
    end
  end

endmodule

// ===== rtl/u16u8_serializer.sv =====
// Byte serializer: steps through the encoded bytes of one unit into the
// result register and keeps the saturating byte count. Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_serializer import u16u8_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic         last_i,
  input  enc_t         enc_i,
  output logic         retire_o,
  u16u8_byte_if.source byte_o
);

  logic        out_valid_q;
  byte_t       out_data_q;
  logic [1:0]  idx_q;
  logic [15:0] total_q;
  logic [15:0] total_inc;
  logic        out_free;
  logic        load;
  logic        final_byte;

  assign out_free   = !out_valid_q || byte_o.ready;
  assign load       = valid_i && (enc_i.nbytes != 3'd0) && out_free;
  assign final_byte = (({1'b0, idx_q} + 3'd1) == enc_i.nbytes);
  assign retire_o   = valid_i && ((enc_i.nbytes == 3'd0) || (load && final_byte));
  assign total_inc  = (total_q == COUNT_MAX) ? total_q : total_q + 16'd1;

  assign byte_o.valid = out_valid_q;
  assign byte_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      total_q     <= 16'd0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= final_byte ? 2'd0 : idx_q + 2'd1;
      total_q     <= (final_byte && last_i) ? 16'd0 : total_inc;
    end else if (byte_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.out_byte      <= enc_i.bytes[idx_q];
      out_data_q.last_of_unit  <= final_byte;
      out_data_q.end_of_string <= final_byte && last_i;
      out_data_q.bytes_so_far  <= total_inc;
    end
  end

endmodule

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder: input register, surrogate
// state, encoder and byte serializer. Depends on u16u8_pkg, u16u8_intf,
// u16u8_encoder, u16u8_serializer and utf16_to_utf8_transcoder_assert.svh.
//
//   channel  dir  word                                   handshake
//   unit_i   in   code_unit[15:0], last_unit             valid/ready
//   byte_o   out  out_byte[7:0], last_of_unit,           valid/ready
//                 end_of_string, bytes_so_far[15:0]
//
// A unit takes one cycle per UTF-8 byte it yields (1 to 4) while byte_o does not stall,
// set by the single result register; a held leading surrogate yields no byte.
// A taken unit waits in the input register; its first byte is then loaded into
// the result register and offered from there.
// Reset clears surrogate state, byte count and both valid flags.
// A stalled result register holds; the input register takes the next unit
// in the cycle its predecessor loads its last byte into the result register.
`timescale 1ns / 1ps

`include "utf16_to_utf8_transcoder_assert.svh"

module utf16_to_utf8_transcoder import u16u8_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  u16u8_unit_if.sink   unit_i,
  u16u8_byte_if.source byte_o
);

  logic       s1_valid_q;
  unit_t      s1_data_q;
  logic       pend_valid_q;
  logic [9:0] pend_bits_q;
  enc_t       enc;
  logic       retire;
  logic       accept;

  assign unit_i.ready = !s1_valid_q || retire;
  assign accept       = unit_i.valid && unit_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_bits_q  <= 10'd0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (retire) begin
        s1_valid_q <= 1'b0;
      end
      if (retire) begin
        pend_valid_q <= enc.hold;
        pend_bits_q  <= enc.hold ? s1_data_q.code_unit[9:0] : 10'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= unit_i.data;
    end
  end

  u16u8_encoder u_encoder (
    .unit_i       (s1_data_q.code_unit),
    .last_i       (s1_data_q.last_unit),
    .pend_valid_i (pend_valid_q),
    .pend_bits_i  (pend_bits_q),
    .enc_o        (enc)
  );

  u16u8_serializer u_serializer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid_q),
    .last_i   (s1_data_q.last_unit),
    .enc_i    (enc),
    .retire_o (retire),
    .byte_o   (byte_o)
  );

  `U16U8_ASSERT_IMP(a_hold_passes, s1_valid_q && enc.hold, retire,
                    "held surrogate stalled")
  `U16U8_ASSERT_NXT(a_last_clears, retire && s1_data_q.last_unit, !pend_valid_q,
                    "state kept after last unit")
  `U16U8_ASSERT_IMP(a_eos_final, byte_o.valid && byte_o.data.end_of_string,
                    byte_o.data.last_of_unit, "end of string not on final byte")
  `U16U8_ASSERT_IMP(a_count_nonzero, byte_o.valid, byte_o.data.bytes_so_far != 16'd0,
                    "zero byte count")

endmodule
